/* rtl/core/cmcd_pkg.sv */
// Package for the console MIDI CC decoder: codes, layout constants, config and
// decoded-record types, and the position scaling functions. No dependencies.
package cmcd_pkg;

    localparam int MAX_STRIPS_PER_SIDE = 32;
    localparam int CountW = 6;
    localparam int ChanW = 5;
    localparam int StripW = 6;
    localparam int SlotW = StripW + 1;
    localparam int CacheDepth = 1 << SlotW;
    localparam int QueueDepth = 2;

    // register indexes
    localparam logic [2:0] REG_LO_COUNT = 3'd0;
    localparam logic [2:0] REG_HI_COUNT = 3'd1;
    localparam logic [2:0] REG_LO_FCH = 3'd2;
    localparam logic [2:0] REG_HI_FCH = 3'd3;
    localparam logic [2:0] REG_LO_CCH = 3'd4;
    localparam logic [2:0] REG_HI_CCH = 3'd5;
    localparam logic [2:0] REG_MASTER_CH = 3'd6;
    localparam logic [2:0] REG_FLAGS = 3'd7;

    // feature flag bits
    localparam int FLAG_MASTER = 0;
    localparam int FLAG_JOY1 = 1;
    localparam int FLAG_JOY2 = 2;
    localparam int FLAG_AUX = 3;
    localparam int FLAG_FINE = 4;

    // fixed controller numbers
    localparam logic [6:0] CC_MASTER_COARSE = 7'd0;
    localparam logic [6:0] CC_MASTER_FINE = 7'd1;
    localparam logic [6:0] CC_MASTER_SEL = 7'd64;
    localparam logic [6:0] CC_JOY_AXIS = 7'd48;
    localparam logic [6:0] CC_JOY_MUTE = 7'd24;
    localparam logic [6:0] CC_AUX_MUTE = 7'd96;

    localparam logic [6:0] VAL_MUTE_ON = 7'd3;
    localparam logic [6:0] VAL_TOUCH_BEGIN = 7'd6;
    localparam logic [6:0] VAL_TOUCH_END = 7'd5;
    localparam logic [6:0] VAL_SEL = 7'd1;
    localparam logic [6:0] VAL_AUX_MIN = 7'd2;
    localparam logic [6:0] VAL_AUX_MAX = 7'd21;

    typedef enum logic [3:0] {
        EV_UNKNOWN = 4'd0,
        EV_IGNORED = 4'd1,
        EV_POSITION = 4'd2,
        EV_MUTE = 4'd3,
        EV_TOUCH_BEGIN = 4'd4,
        EV_TOUCH_END = 4'd5,
        EV_SEL = 4'd6,
        EV_MASTER_SEL = 4'd7,
        EV_AUX_MUTE = 4'd8
    } event_kind_t;

    typedef enum logic [2:0] {
        CL_FADER = 3'd0,
        CL_MUTE = 3'd1,
        CL_TOUCH = 3'd2,
        CL_JOY_AXIS = 3'd3,
        CL_JOY_MUTE = 3'd4,
        CL_MASTER_FADER = 3'd5,
        CL_MASTER_SEL = 3'd6,
        CL_AUX_MUTE = 3'd7
    } control_class_t;

    typedef struct packed {
        logic [CountW-1:0] lo_count;
        logic [CountW-1:0] hi_count;
        logic [ChanW-1:0] lo_fch;
        logic [ChanW-1:0] hi_fch;
        logic [ChanW-1:0] lo_cch;
        logic [ChanW-1:0] hi_cch;
        logic [ChanW-1:0] master_ch;
        logic [4:0] flags;
    } cfg_t;

    // one classified message, front to back
    typedef struct packed {
        logic used;
        control_class_t cls;
        logic [StripW-1:0] strip;
        logic path;
        logic [3:0] idx;
        logic fine_comb;
        logic [ChanW-1:0] ch;
        logic [6:0] cc;
        logic [6:0] v;
    } dec_t;

    // floor(v*32768/127) = 258*v + floor(2*v/127)
    function automatic logic [15:0] pos7(input logic [6:0] v);
        logic [15:0] base;
        logic [15:0] corr;
        base = (16'(v) << 8) + (16'(v) << 1);
        corr = (v == 7'd127) ? 16'd2 : (v[6] ? 16'd1 : 16'd0);
        return base + corr;
    endfunction

    // floor(c*32768/16383) = 2*c + floor(2*c/16383)
    function automatic logic [15:0] pos14(input logic [6:0] hi, input logic [6:0] lo);
        logic [13:0] comb;
        logic [15:0] corr;
        comb = {hi, lo};
        corr = (comb == 14'h3FFF) ? 16'd2 : (comb[13] ? 16'd1 : 16'd0);
        return (16'(comb) << 1) + corr;
    endfunction

endpackage

/* rtl/core/cmcd_if.sv */
// Valid/ready channel interfaces: incoming CC messages and decoded events.
// Depends on cmcd_pkg.
interface cmcd_msg_if;
    logic valid;
    logic ready;
    logic [7:0] status_byte;
    logic [6:0] controller;
    logic [6:0] data_value;

    modport source (output valid, output status_byte, output controller,
                    output data_value, input ready);
    modport sink (input valid, input status_byte, input controller,
                  input data_value, output ready);
endinterface

interface cmcd_evt_if;
    logic valid;
    logic ready;
    logic [3:0] event_kind;
    logic [2:0] control_class;
    logic [cmcd_pkg::StripW-1:0] strip_number;
    logic path_select;
    logic [3:0] control_index;
    logic on_flag;
    logic [15:0] position;
    logic [cmcd_pkg::ChanW-1:0] channel_out;
    logic [6:0] controller_out;
    logic [6:0] value_out;

    modport source (output valid, output event_kind, output control_class,
                    output strip_number, output path_select, output control_index,
                    output on_flag, output position, output channel_out,
                    output controller_out, output value_out, input ready);
    modport sink (input valid, input event_kind, input control_class,
                  input strip_number, input path_select, input control_index,
                  input on_flag, input position, input channel_out,
                  input controller_out, input value_out, output ready);
endinterface

/* rtl/core/cmcd_front.sv */
// Front end: accepts a CC beat and maps (channel, controller) to a control.
// Depends on cmcd_pkg and cmcd_if.
module cmcd_front (
    cmcd_msg_if.sink msg_in,
    input  cmcd_pkg::cfg_t cfg,
    input  logic q_full,
    output logic push,
    output cmcd_pkg::dec_t push_data
);

    logic [cmcd_pkg::ChanW-1:0] ch;
    logic [6:0] cc;
    logic [cmcd_pkg::CountW-1:0] lo_sat, hi_sat;
    logic [4:0] wf, wc;
    logic fd_lo, fd_hi, ct_lo, ct_hi;
    // key = {strip, path, later-class}; the larger key is defined later
    logic [cmcd_pkg::StripW+1:0] k_fd_lo, k_fd_hi, k_ct_lo, k_ct_hi;
    logic [cmcd_pkg::StripW+1:0] k_fd, k_ct, k_win;
    logic fd_any, ct_any;
    logic j0_axis, j1_axis, j0_mute, j1_mute;
    cmcd_pkg::dec_t d;

    assign msg_in.ready = !q_full;
    assign push = msg_in.valid && !q_full;

    always_comb
    begin
        ch = {1'b0, msg_in.status_byte[3:0]} + 5'd1;
        cc = msg_in.controller;
        lo_sat = (cfg.lo_count > 6'(cmcd_pkg::MAX_STRIPS_PER_SIDE))
                 ? 6'(cmcd_pkg::MAX_STRIPS_PER_SIDE) : cfg.lo_count;
        hi_sat = (cfg.hi_count > 6'(cmcd_pkg::MAX_STRIPS_PER_SIDE))
                 ? 6'(cmcd_pkg::MAX_STRIPS_PER_SIDE) : cfg.hi_count;
        wf = cc[6:2];
        wc = cc[5:1];

        fd_lo = (ch == cfg.lo_fch) && ({1'b0, wf} < lo_sat);
        fd_hi = (ch == cfg.hi_fch) && ({1'b0, wf} < hi_sat);
        ct_lo = (ch == cfg.lo_cch) && ({1'b0, wc} < lo_sat);
        ct_hi = (ch == cfg.hi_cch) && ({1'b0, wc} < hi_sat);

        k_fd_lo = {{1'b0, wf}, cc[1], 1'b0};
        k_fd_hi = {lo_sat + {1'b0, wf}, cc[1], 1'b0};
        k_ct_lo = {{1'b0, wc}, cc[0], 1'b1};
        k_ct_hi = {lo_sat + {1'b0, wc}, cc[0], 1'b1};

        fd_any = fd_lo || fd_hi;
        ct_any = ct_lo || ct_hi;
        k_fd = fd_hi ? k_fd_hi : k_fd_lo;
        k_ct = ct_hi ? k_ct_hi : k_ct_lo;
        if (fd_any && ct_any)
        begin
            k_win = (k_ct > k_fd) ? k_ct : k_fd;
        end
        else
        begin
            k_win = ct_any ? k_ct : k_fd;
        end

        d = '0;
        d.ch = ch;
        d.cc = cc;
        d.v = msg_in.data_value;
        if (fd_any || ct_any)
        begin
            d.used = 1'b1;
            d.strip = k_win[cmcd_pkg::StripW+1:2];
            d.path = k_win[1];
            if (!k_win[0])
            begin
                d.cls = cmcd_pkg::CL_FADER;
                d.fine_comb = cc[0] && cfg.flags[cmcd_pkg::FLAG_FINE];
            end
            else
            begin
                d.cls = cc[6] ? cmcd_pkg::CL_TOUCH : cmcd_pkg::CL_MUTE;
            end
        end

        if (cfg.flags[cmcd_pkg::FLAG_MASTER] && (ch == cfg.master_ch))
        begin
            if ((cc == cmcd_pkg::CC_MASTER_COARSE) || (cc == cmcd_pkg::CC_MASTER_FINE))
            begin
                d.used = 1'b1;
                d.cls = cmcd_pkg::CL_MASTER_FADER;
                d.strip = '0;
                d.path = 1'b0;
                d.idx = '0;
                d.fine_comb = 1'b0;
            end
            else if (cc == cmcd_pkg::CC_MASTER_SEL)
            begin
                d.used = 1'b1;
                d.cls = cmcd_pkg::CL_MASTER_SEL;
                d.strip = '0;
                d.path = 1'b0;
                d.idx = '0;
                d.fine_comb = 1'b0;
            end
        end

        j0_axis = cfg.flags[cmcd_pkg::FLAG_JOY1] && (ch == cfg.hi_fch)
                  && (cc[6:2] == cmcd_pkg::CC_JOY_AXIS[6:2]) && !cc[0];
        j1_axis = cfg.flags[cmcd_pkg::FLAG_JOY2] && (ch == cfg.hi_fch)
                  && (cc[6:2] == (cmcd_pkg::CC_JOY_AXIS[6:2] + 5'd1)) && !cc[0];
        j0_mute = cfg.flags[cmcd_pkg::FLAG_JOY1] && (ch == cfg.hi_cch)
                  && (cc == cmcd_pkg::CC_JOY_MUTE);
        j1_mute = cfg.flags[cmcd_pkg::FLAG_JOY2] && (ch == cfg.hi_cch)
                  && (cc == (cmcd_pkg::CC_JOY_MUTE + 7'd2));
        if (j0_axis || j1_axis || j0_mute || j1_mute)
        begin
            d.used = 1'b1;
            d.cls = (j0_axis || j1_axis) ? cmcd_pkg::CL_JOY_AXIS : cmcd_pkg::CL_JOY_MUTE;
            d.strip = '0;
            d.path = (j0_axis || j1_axis) ? cc[1] : 1'b0;
            d.idx = {3'b000, j1_axis || j1_mute};
            d.fine_comb = 1'b0;
        end

        if (cfg.flags[cmcd_pkg::FLAG_AUX] && (ch == cfg.master_ch)
            && (cc == cmcd_pkg::CC_AUX_MUTE))
        begin
            d.used = 1'b1;
            d.cls = cmcd_pkg::CL_AUX_MUTE;
            d.strip = '0;
            d.path = 1'b0;
            d.idx = '0;
            d.fine_comb = 1'b0;
        end

        push_data = d;
    end

endmodule

/* rtl/core/cmcd_queue.sv */
// Two-entry queue of classified messages between front and back end.
// Depends on cmcd_pkg.
module cmcd_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmcd_pkg::dec_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmcd_pkg::dec_t pop_data
);

    cmcd_pkg::dec_t entry_reg [cmcd_pkg::QueueDepth];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full = (count_reg == 2'(cmcd_pkg::QueueDepth));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/cmcd_back.sv */
// Back end: fader coarse cache read, event classification, position scaling
// and the output register. Depends on cmcd_pkg and cmcd_if.
module cmcd_back (
    input  logic clk,
    input  logic rst_n,
    input  logic q_not_empty,
    input  cmcd_pkg::dec_t q_data,
    output logic pop,
    cmcd_evt_if.source evt_out
);

    logic [6:0] cache_mem [cmcd_pkg::CacheDepth];
    logic [cmcd_pkg::CacheDepth-1:0] cache_vld_reg;
    logic [6:0] rd_data_reg;
    logic rd_vld_reg;
    logic fwd_hit_reg;
    logic [6:0] fwd_val_reg;

    logic s2_valid_reg;
    cmcd_pkg::dec_t s2_reg;
    logic out_valid_reg;

    logic s2_adv;
    logic [cmcd_pkg::SlotW-1:0] rd_slot, wr_slot;
    logic wr_en;
    logic [6:0] coarse;

    cmcd_pkg::event_kind_t kind_next, kind_reg;
    logic [2:0] class_next, class_reg;
    logic [cmcd_pkg::StripW-1:0] strip_next, strip_reg;
    logic path_next, path_reg;
    logic [3:0] idx_next, idx_reg;
    logic on_next, on_reg;
    logic [15:0] pos_next, pos_reg;
    logic [cmcd_pkg::ChanW-1:0] ch_reg;
    logic [6:0] cc_reg, v_reg;

    assign s2_adv = s2_valid_reg && (!out_valid_reg || evt_out.ready);
    assign pop = q_not_empty && (!s2_valid_reg || s2_adv);
    assign rd_slot = {q_data.strip, q_data.path};
    assign wr_slot = {s2_reg.strip, s2_reg.path};
    assign wr_en = s2_adv && s2_reg.used && (s2_reg.cls == cmcd_pkg::CL_FADER)
                   && !s2_reg.fine_comb;
    // a write in the same beat as the read is forwarded
    assign coarse = fwd_hit_reg ? fwd_val_reg : (rd_vld_reg ? rd_data_reg : 7'd0);

    always_comb
    begin
        kind_next = cmcd_pkg::EV_UNKNOWN;
        class_next = 3'd0;
        strip_next = '0;
        path_next = 1'b0;
        idx_next = '0;
        on_next = 1'b0;
        pos_next = '0;
        if (s2_reg.used)
        begin
            class_next = s2_reg.cls;
            strip_next = s2_reg.strip;
            path_next = s2_reg.path;
            idx_next = s2_reg.idx;
            unique case (s2_reg.cls)
                cmcd_pkg::CL_FADER:
                begin
                    kind_next = cmcd_pkg::EV_POSITION;
                    pos_next = s2_reg.fine_comb ? cmcd_pkg::pos14(coarse, s2_reg.v)
                                                : cmcd_pkg::pos7(s2_reg.v);
                end
                cmcd_pkg::CL_MUTE, cmcd_pkg::CL_JOY_MUTE:
                begin
                    kind_next = cmcd_pkg::EV_MUTE;
                    on_next = (s2_reg.v == cmcd_pkg::VAL_MUTE_ON);
                end
                cmcd_pkg::CL_TOUCH:
                begin
                    if (s2_reg.v == cmcd_pkg::VAL_TOUCH_BEGIN)
                        kind_next = cmcd_pkg::EV_TOUCH_BEGIN;
                    else if (s2_reg.v == cmcd_pkg::VAL_TOUCH_END)
                        kind_next = cmcd_pkg::EV_TOUCH_END;
                    else if (s2_reg.v == cmcd_pkg::VAL_SEL)
                        kind_next = cmcd_pkg::EV_SEL;
                    else
                        kind_next = cmcd_pkg::EV_IGNORED;
                end
                cmcd_pkg::CL_JOY_AXIS, cmcd_pkg::CL_MASTER_FADER:
                begin
                    kind_next = cmcd_pkg::EV_POSITION;
                    pos_next = cmcd_pkg::pos7(s2_reg.v);
                end
                cmcd_pkg::CL_MASTER_SEL:
                begin
                    kind_next = (s2_reg.v == cmcd_pkg::VAL_SEL) ? cmcd_pkg::EV_MASTER_SEL
                                                                : cmcd_pkg::EV_IGNORED;
                end
                default:
                begin
                    if ((s2_reg.v >= cmcd_pkg::VAL_AUX_MIN) && (s2_reg.v <= cmcd_pkg::VAL_AUX_MAX))
                    begin
                        kind_next = cmcd_pkg::EV_AUX_MUTE;
                        idx_next = 4'((s2_reg.v - cmcd_pkg::VAL_AUX_MIN) >> 1);
                        on_next = s2_reg.v[0];
                    end
                    else
                    begin
                        kind_next = cmcd_pkg::EV_IGNORED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cache_vld_reg <= '0;
        end
        else
        begin
            if (pop)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;
            if (s2_adv)
                out_valid_reg <= 1'b1;
            else if (evt_out.ready)
                out_valid_reg <= 1'b0;
            if (wr_en)
                cache_vld_reg[wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cache_mem[wr_slot] <= s2_reg.v;
        if (pop)
        begin
            s2_reg <= q_data;
            rd_data_reg <= cache_mem[rd_slot];
            rd_vld_reg <= cache_vld_reg[rd_slot];
            fwd_hit_reg <= wr_en && (wr_slot == rd_slot);
            fwd_val_reg <= s2_reg.v;
        end
        if (s2_adv)
        begin
            kind_reg <= kind_next;
            class_reg <= class_next;
            strip_reg <= strip_next;
            path_reg <= path_next;
            idx_reg <= idx_next;
            on_reg <= on_next;
            pos_reg <= pos_next;
            ch_reg <= s2_reg.ch;
            cc_reg <= s2_reg.cc;
            v_reg <= s2_reg.v;
        end
    end

    assign evt_out.valid = out_valid_reg;
    assign evt_out.event_kind = kind_reg;
    assign evt_out.control_class = class_reg;
    assign evt_out.strip_number = strip_reg;
    assign evt_out.path_select = path_reg;
    assign evt_out.control_index = idx_reg;
    assign evt_out.on_flag = on_reg;
    assign evt_out.position = pos_reg;
    assign evt_out.channel_out = ch_reg;
    assign evt_out.controller_out = cc_reg;
    assign evt_out.value_out = v_reg;

endmodule

/* rtl/core/console_midi_cc_decoder_core.sv */
// Console MIDI CC decoder, top level: config registers, front, queue, back.
// Input beat to result beat passes the queue, the cache read and the output reg.
// Throughput: one beat per cycle while evt_out is ready; the coarse cache has one read
// and one write port, used once each per beat, with same-slot writes forwarded.
// Reset: counts 0, channels 1, flags 0; coarse cache reads as zero until written.
// Depends on cmcd_pkg, cmcd_if, cmcd_front, cmcd_queue, cmcd_back.
module console_midi_cc_decoder_core (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [cmcd_pkg::CountW-1:0] cfg_data,
    cmcd_msg_if.sink msg_in,
    cmcd_evt_if.source evt_out
);

    cmcd_pkg::cfg_t cfg_reg;
    logic push, q_full, q_pop, q_not_empty;
    cmcd_pkg::dec_t push_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lo_count <= '0;
            cfg_reg.hi_count <= '0;
            cfg_reg.lo_fch <= 5'd1;
            cfg_reg.hi_fch <= 5'd1;
            cfg_reg.lo_cch <= 5'd1;
            cfg_reg.hi_cch <= 5'd1;
            cfg_reg.master_ch <= 5'd1;
            cfg_reg.flags <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmcd_pkg::REG_LO_COUNT:  cfg_reg.lo_count <= cfg_data;
                cmcd_pkg::REG_HI_COUNT:  cfg_reg.hi_count <= cfg_data;
                cmcd_pkg::REG_LO_FCH:    cfg_reg.lo_fch <= cfg_data[4:0];
                cmcd_pkg::REG_HI_FCH:    cfg_reg.hi_fch <= cfg_data[4:0];
                cmcd_pkg::REG_LO_CCH:    cfg_reg.lo_cch <= cfg_data[4:0];
                cmcd_pkg::REG_HI_CCH:    cfg_reg.hi_cch <= cfg_data[4:0];
                cmcd_pkg::REG_MASTER_CH: cfg_reg.master_ch <= cfg_data[4:0];
                default:                 cfg_reg.flags <= cfg_data[4:0];
            endcase
        end
    end

    cmcd_front u_front (
        .msg_in    (msg_in),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    cmcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    cmcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (q_pop),
        .evt_out     (evt_out)
    );

`ifndef SYNTHESIS
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_in.valid && msg_in.ready) |=> q_not_empty)
        else $error("accepted beat did not reach the queue");
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == cmcd_pkg::REG_LO_COUNT)) |=>
        (cfg_reg.lo_count == $past(cfg_data)))
        else $error("strip count write lost");
`endif

endmodule

/* tb/cmcd_checker.sv */
// Scoreboard for console_midi_cc_decoder_core: shadows the config registers and
// the coarse fader cache, predicts each decoded event and checks the output beats.
// Depends on cmcd_pkg and cmcd_if.
`timescale 1ns / 100ps

module cmcd_checker
    import cmcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [CountW-1:0] cfg_data,
    cmcd_msg_if msg,
    cmcd_evt_if evt,
    output int fail_count,
    output int pending
);

    typedef struct packed {
        event_kind_t kind;
        control_class_t cls;
        logic [5:0] strip;
        logic path;
        logic [3:0] idx;
        logic on;
        logic [15:0] pos;
        logic [4:0] ch;
        logic [6:0] cc;
        logic [6:0] v;
    } cc_event_t;

    logic [5:0] lo_cnt, hi_cnt;
    logic [4:0] lo_fch, hi_fch, lo_cch, hi_cch, master_ch, flags;
    logic [6:0] coarse_cache [128];
    cc_event_t event_q[$];
    int mismatches;

    // later matches overwrite earlier ones, same priority as the layout order
    function automatic cc_event_t decode_cc(input logic [7:0] st, input logic [6:0] cc,
                                            input logic [6:0] v);
        cc_event_t e;
        int lo, hi, w, ch, fch, cch, strip, path, idx, slot, comb;
        logic hit, fine;
        control_class_t cls;
        e = '0;
        ch = int'(st[3:0]) + 1;
        hit = 0; fine = 0; cls = CL_FADER; strip = 0; path = 0; idx = 0;
        lo = (lo_cnt > MAX_STRIPS_PER_SIDE) ? MAX_STRIPS_PER_SIDE : int'(lo_cnt);
        hi = (hi_cnt > MAX_STRIPS_PER_SIDE) ? MAX_STRIPS_PER_SIDE : int'(hi_cnt);
        for (int s = 0; s < lo + hi; s++)
        begin
            w = (s < lo) ? s : s - lo;
            fch = (s < lo) ? int'(lo_fch) : int'(hi_fch);
            cch = (s < lo) ? int'(lo_cch) : int'(hi_cch);
            for (int p = 0; p < 2; p++)
            begin
                if (ch == fch && cc == 4 * w + 2 * p)
                begin
                    hit = 1; cls = CL_FADER; strip = s; path = p; idx = 0; fine = 0;
                end
                if (ch == fch && cc == 4 * w + 2 * p + 1)
                begin
                    hit = 1; cls = CL_FADER; strip = s; path = p; idx = 0; fine = 1;
                end
                if (ch == cch && cc == 2 * w + p)
                begin
                    hit = 1; cls = CL_MUTE; strip = s; path = p; idx = 0; fine = 0;
                end
                if (ch == cch && cc == 64 + 2 * w + p)
                begin
                    hit = 1; cls = CL_TOUCH; strip = s; path = p; idx = 0; fine = 0;
                end
            end
        end
        if (flags[FLAG_MASTER] && ch == int'(master_ch))
        begin
            if (cc == CC_MASTER_COARSE || cc == CC_MASTER_FINE)
            begin
                hit = 1; cls = CL_MASTER_FADER; strip = 0; path = 0; idx = 0; fine = 0;
            end
            if (cc == CC_MASTER_SEL)
            begin
                hit = 1; cls = CL_MASTER_SEL; strip = 0; path = 0; idx = 0; fine = 0;
            end
        end
        for (int j = 0; j < 2; j++)
        begin
            if (flags[FLAG_JOY1 + j])
            begin
                for (int a = 0; a < 2; a++)
                    if (ch == int'(hi_fch) && cc == 48 + 4 * j + 2 * a)
                    begin
                        hit = 1; cls = CL_JOY_AXIS; strip = 0; path = a; idx = j; fine = 0;
                    end
                if (ch == int'(hi_cch) && cc == 24 + 2 * j)
                begin
                    hit = 1; cls = CL_JOY_MUTE; strip = 0; path = 0; idx = j; fine = 0;
                end
            end
        end
        if (flags[FLAG_AUX] && ch == int'(master_ch) && cc == CC_AUX_MUTE)
        begin
            hit = 1; cls = CL_AUX_MUTE; strip = 0; path = 0; idx = 0; fine = 0;
        end

        e.ch = ch[4:0];
        e.cc = cc;
        e.v = v;
        e.kind = EV_UNKNOWN;
        if (!hit)
            return e;
        e.cls = cls;
        e.strip = strip[5:0];
        e.path = path[0];
        e.idx = idx[3:0];
        case (cls)
            CL_FADER:
            begin
                slot = (strip * 2 + path) & 127;
                e.kind = EV_POSITION;
                if (flags[FLAG_FINE] && fine)
                begin
                    comb = int'(coarse_cache[slot]) * 128 + int'(v);
                    e.pos = 16'((comb * 32768) / 16383);
                end
                else
                begin
                    coarse_cache[slot] = v;
                    e.pos = 16'((int'(v) * 32768) / 127);
                end
            end
            CL_MUTE, CL_JOY_MUTE:
            begin
                e.kind = EV_MUTE;
                e.on = (v == 7'd3);
            end
            CL_TOUCH:
                e.kind = (v == 7'd6) ? EV_TOUCH_BEGIN : (v == 7'd5) ? EV_TOUCH_END :
                         (v == 7'd1) ? EV_SEL : EV_IGNORED;
            CL_JOY_AXIS, CL_MASTER_FADER:
            begin
                e.kind = EV_POSITION;
                e.pos = 16'((int'(v) * 32768) / 127);
            end
            CL_MASTER_SEL:
                e.kind = (v == 7'd1) ? EV_MASTER_SEL : EV_IGNORED;
            default:
            begin
                if (v >= 7'd2 && v <= 7'd21)
                begin
                    e.kind = EV_AUX_MUTE;
                    e.idx = 4'((int'(v) - 2) / 2);
                    e.on = v[0];
                end
                else
                    e.kind = EV_IGNORED;
            end
        endcase
        return e;
    endfunction

    function automatic void report(input string what, input cc_event_t x, input cc_event_t a);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: exp kind=%0d cls=%0d strip=%0d path=%0d idx=%0d on=%0d pos=%0d ch=%0d cc=%0d v=%0d | act kind=%0d cls=%0d strip=%0d path=%0d idx=%0d on=%0d pos=%0d ch=%0d cc=%0d v=%0d",
                     $time, what, x.kind, x.cls, x.strip, x.path, x.idx, x.on, x.pos,
                     x.ch, x.cc, x.v, a.kind, a.cls, a.strip, a.path, a.idx, a.on,
                     a.pos, a.ch, a.cc, a.v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cc_event_t got, want;
        if (!rst_n)
        begin
            lo_cnt = '0; hi_cnt = '0;
            lo_fch = 5'd1; hi_fch = 5'd1; lo_cch = 5'd1; hi_cch = 5'd1; master_ch = 5'd1;
            flags = '0;
            for (int i = 0; i < 128; i++)
                coarse_cache[i] = '0;
            event_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LO_COUNT:  lo_cnt = cfg_data;
                    REG_HI_COUNT:  hi_cnt = cfg_data;
                    REG_LO_FCH:    lo_fch = cfg_data[4:0];
                    REG_HI_FCH:    hi_fch = cfg_data[4:0];
                    REG_LO_CCH:    lo_cch = cfg_data[4:0];
                    REG_HI_CCH:    hi_cch = cfg_data[4:0];
                    REG_MASTER_CH: master_ch = cfg_data[4:0];
                    default:       flags = cfg_data[4:0];
                endcase
            end
            if (evt.valid && evt.ready)
            begin
                got = {event_kind_t'(evt.event_kind), control_class_t'(evt.control_class),
                       evt.strip_number, evt.path_select, evt.control_index, evt.on_flag,
                       evt.position, evt.channel_out, evt.controller_out, evt.value_out};
                if (event_q.size() == 0)
                    report("unexpected beat", '0, got);
                else
                begin
                    want = event_q.pop_front();
                    if (got !== want)
                        report("mismatch", want, got);
                end
            end
            if (msg.valid && msg.ready)
                event_q.insert(event_q.size(),
                               decode_cc(msg.status_byte, msg.controller, msg.data_value));
            fail_count <= mismatches;
            pending <= event_q.size();
        end
    end

endmodule

/* tb/tb_console_midi_cc_decoder_core.sv */
// Top of the console_midi_cc_decoder_core regression: clock, reset, config
// phases and CC stimulus with random idling; checking is done in cmcd_checker.
// Depends on cmcd_pkg, cmcd_if, cmcd_checker and the decoder RTL.
`timescale 1ns / 100ps

module tb_console_midi_cc_decoder_core;
    import cmcd_pkg::*;

    localparam int CycleLimit = 300000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [CountW-1:0] cfg_data;
    int fail_count, pending, cycles, tx_idle, rx_idle;
    logic [4:0] layout_ch [5];

    cmcd_msg_if msg_if ();
    cmcd_evt_if evt_if ();

    console_midi_cc_decoder_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .msg_in(msg_if), .evt_out(evt_if)
    );

    cmcd_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .msg(msg_if), .evt(evt_if),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("console_midi_cc_decoder_core regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
        evt_if.ready <= rst_n && ($urandom_range(99) >= rx_idle);

    // ready only moves at rising edges, so its value mid-cycle is the one the
    // next edge sees
    task automatic send_cc(input logic [7:0] st, input logic [6:0] cc, input logic [6:0] v);
        if (tx_idle > 0 && $urandom_range(99) < tx_idle)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle)
                @(posedge clk);
        end
        msg_if.valid <= 1'b1;
        msg_if.status_byte <= st;
        msg_if.controller <= cc;
        msg_if.data_value <= v;
        @(negedge clk);
        while (!msg_if.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CountW-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    task automatic set_layout(input logic [5:0] lo, input logic [5:0] hi,
                              input logic [4:0] lfch, input logic [4:0] hfch,
                              input logic [4:0] lcch, input logic [4:0] hcch,
                              input logic [4:0] mch, input logic [4:0] flg);
        write_reg(REG_LO_COUNT, lo);
        write_reg(REG_HI_COUNT, hi);
        write_reg(REG_LO_FCH, 6'(lfch));
        write_reg(REG_HI_FCH, 6'(hfch));
        write_reg(REG_LO_CCH, 6'(lcch));
        write_reg(REG_HI_CCH, 6'(hcch));
        write_reg(REG_MASTER_CH, 6'(mch));
        write_reg(REG_FLAGS, 6'(flg));
        cfg_we <= 1'b0;
        layout_ch[0] = lfch; layout_ch[1] = hfch; layout_ch[2] = lcch;
        layout_ch[3] = hcch; layout_ch[4] = mch;
    endtask

    // mostly messages on a configured channel with values that hit the decode cases
    task automatic send_random_cc();
        logic [4:0] ch;
        logic [7:0] st;
        logic [6:0] v;
        int special [10] = '{0, 1, 2, 3, 5, 6, 21, 22, 127, 64};
        st = 8'($urandom);
        ch = layout_ch[$urandom_range(4)];
        if ($urandom_range(9) < 8 && ch >= 5'd1 && ch <= 5'd16)
            st[3:0] = 4'(ch - 5'd1);
        v = ($urandom_range(1) == 0) ? 7'(special[$urandom_range(9)]) : 7'($urandom);
        send_cc(st, 7'($urandom), v);
    endtask

    initial
    begin
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        msg_if.valid = 1'b0;
        msg_if.status_byte = '0;
        msg_if.controller = '0;
        msg_if.data_value = '0;
        evt_if.ready = 1'b0;
        tx_idle = 32;
        rx_idle = 82;
        for (int i = 0; i < 5; i++)
            layout_ch[i] = 5'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: nothing matches
        send_cc(8'hB0, 7'd0, 7'd64);
        wait_idle();

        set_layout(6'd2, 6'd2, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd31);
        send_cc(8'hB0, 7'd0, 7'd127);       // coarse, then fine in 14-bit mode
        send_cc(8'hB0, 7'd1, 7'd127);
        send_cc(8'h00, 7'd6, 7'd0);
        send_cc(8'hB0, 7'd7, 7'd64);        // fine with zero coarse
        send_cc(8'hB2, 7'd0, 7'd3);         // mute on / off
        send_cc(8'hB2, 7'd1, 7'd0);
        send_cc(8'hB2, 7'd64, 7'd6);        // touch begin, end, sel, ignored
        send_cc(8'hB2, 7'd65, 7'd5);
        send_cc(8'hB2, 7'd66, 7'd1);
        send_cc(8'hB2, 7'd67, 7'd7);
        send_cc(8'hF1, 7'd5, 7'd127);       // high side, fine
        send_cc(8'hB4, 7'd0, 7'd127);       // master fader
        send_cc(8'hB4, 7'd1, 7'd1);
        send_cc(8'hB4, 7'd64, 7'd1);        // master sel, ignored
        send_cc(8'hB4, 7'd64, 7'd0);
        send_cc(8'hB1, 7'd50, 7'd100);      // joystick axes
        send_cc(8'hB1, 7'd54, 7'd127);
        send_cc(8'hB3, 7'd24, 7'd3);        // joystick mutes
        send_cc(8'hB3, 7'd26, 7'd2);
        send_cc(8'hB4, 7'd96, 7'd2);        // aux range and outside it
        send_cc(8'hB4, 7'd96, 7'd21);
        send_cc(8'hB4, 7'd96, 7'd22);
        send_cc(8'hB4, 7'd96, 7'd1);
        send_cc(8'h8F, 7'd127, 7'd127);     // unknown
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_layout(6'd32, 6'd32, 5'($urandom_range(16, 1)), 5'($urandom_range(16, 1)),
                              5'($urandom_range(16, 1)), 5'($urandom_range(16, 1)),
                              5'($urandom_range(16, 1)), 5'($urandom));
                1: set_layout(6'd63, 6'd0, 5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd16);
                2: set_layout(6'd0, 6'd5, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31);
                default: set_layout(6'($urandom_range(63)), 6'($urandom_range(63)),
                                    5'($urandom_range(3, 1)), 5'($urandom_range(3, 1)),
                                    5'($urandom_range(3, 1)), 5'($urandom_range(3, 1)),
                                    5'($urandom_range(3, 1)), 5'($urandom));
            endcase
            if (ph == 1)
            begin
                tx_idle = 82;
                rx_idle = 32;
            end
            else if (ph >= 2)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            repeat (110) send_random_cc();
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("console_midi_cc_decoder_core regression: pass");
        else
            $display("console_midi_cc_decoder_core regression: fail");
        $finish;
    end

endmodule

/* console_midi_cc_decoder_core.f */
rtl/core/cmcd_pkg.sv
rtl/core/cmcd_if.sv
rtl/core/cmcd_front.sv
rtl/core/cmcd_queue.sv
rtl/core/cmcd_back.sv
rtl/core/console_midi_cc_decoder_core.sv
tb/cmcd_checker.sv
tb/tb_console_midi_cc_decoder_core.sv
